// ===== rtl/core/msa_pkg.sv =====
// Shared types and constants for the multichannel sample averager.
// Used by msa_div and multichannel_sample_averager_unit; no dependencies.
`timescale 1ns / 1ps

package msa_pkg;

    // Field widths of the request and result items
    localparam int MASK_W  = 8;
    localparam int CH_W    = 3;
    localparam int AVG_W   = 10;
    localparam int OUT_W   = 16;   // channel + average, padded to whole bytes

    // Accumulator and window widths
    localparam int SUM_W   = 22;
    localparam int COUNT_W = 12;

    localparam logic [AVG_W-1:0]   AVG_MAX   = 10'h3FF;
    localparam logic [SUM_W-1:0]   SUM_MAX   = 22'h3FFFFF;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 12'hFFF;

    // Divider: one clamp bit plus one bit per average bit
    localparam int QUO_STEPS = AVG_W + 1;
    localparam int STEP_W    = 4;

    // Sequencer states, one-hot
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_ACCUM = 6'b000010,
        S_COUNT = 6'b000100,
        S_SCAN  = 6'b001000,
        S_DIV   = 6'b010000,
        S_EMIT  = 6'b100000
    } state_t;

    // Divider start request
    typedef struct packed {
        logic               start;
        logic [SUM_W-1:0]   dividend;
        logic [COUNT_W-1:0] divisor;
    } div_req_t;

    // Divider status and result
    typedef struct packed {
        logic             busy;
        logic             done;
        logic [AVG_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ===== rtl/core/multichannel_sample_averager_unit.sv =====
// Flow: one request at a time. With no closing window the next request is taken once every
// channel has been accumulated and the event count updated; when the window closes, each
// pending channel is launched on the 11-step serial divider, handed off and rescanned, each
// skipped channel below it is scanned past, and output stalls hold the sequence.
// Reset: sums and event count clear, average_count returns to 1, outputs idle.
// Depends on msa_pkg and msa_div.
`timescale 1ns / 1ps

module multichannel_sample_averager_unit
#(
    parameter int CHANNELS    = 8,
    parameter int SAMPLE_BITS = 10
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    // average_count register
    input  logic                            cfg_wr_en,
    input  logic [msa_pkg::COUNT_W-1:0]     cfg_wr_data,
    // Request: active_mask, sample_ch0 .. sample_ch7, zero padding
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [((msa_pkg::MASK_W + msa_pkg::MASK_W * SAMPLE_BITS + 7) / 8) * 8 - 1:0]
                                            s_tdata,
    // Result: channel, average, zero padding
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [msa_pkg::OUT_W-1:0]       m_tdata,
    output logic                            m_tlast
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    msa_pkg::state_t                  state_reg, state_next;
    logic [IDX_W-1:0]                 idx_reg, idx_next;
    logic [CHANNELS-1:0]              mask_reg, mask_next;
    logic [msa_pkg::COUNT_W-1:0]      count_reg, count_next;
    logic [msa_pkg::COUNT_W-1:0]      divisor_reg, divisor_next;
    logic [msa_pkg::COUNT_W-1:0]      avg_count_reg;
    logic [SAMPLE_BITS-1:0]           samples_reg [CHANNELS];
    logic [msa_pkg::SUM_W-1:0]        sums_reg [CHANNELS];
    logic                             m_tvalid_reg, m_tvalid_next;
    logic [msa_pkg::OUT_W-1:0]        m_tdata_reg;
    logic                             m_tlast_reg;

    logic                             in_accept;
    logic                             idx_last;
    logic                             out_free;
    logic                             out_load;
    logic                             last_flag;
    logic [msa_pkg::COUNT_W-1:0]      window;
    logic [msa_pkg::COUNT_W-1:0]      count_inc;
    logic [msa_pkg::SUM_W:0]          sum_add;
    logic [msa_pkg::SUM_W-1:0]        sum_sat;
    logic                             sum_we;
    logic [msa_pkg::SUM_W-1:0]        sum_wdata;
    msa_pkg::div_req_t                div_req;
    msa_pkg::div_rsp_t                div_rsp;

    assign s_tready  = (state_reg == msa_pkg::S_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign idx_last  = (idx_reg == IDX_W'(CHANNELS - 1));
    assign out_free  = !m_tvalid_reg || m_tready;
    assign out_load  = (state_reg == msa_pkg::S_EMIT) && out_free;
    assign last_flag = ((mask_reg & ~(CHANNELS'(1) << idx_reg)) == '0);
    assign window    = (avg_count_reg == '0) ? msa_pkg::COUNT_W'(1) : avg_count_reg;

    // Saturating count of events with a nonzero mask
    assign count_inc = ((mask_reg != '0) && (count_reg != msa_pkg::COUNT_MAX))
                       ? count_reg + 1'b1 : count_reg;

    // Saturating accumulate of the selected channel
    assign sum_add = {1'b0, sums_reg[idx_reg]} + (msa_pkg::SUM_W + 1)'(samples_reg[idx_reg]);
    assign sum_sat = (sum_add > {1'b0, msa_pkg::SUM_MAX}) ? msa_pkg::SUM_MAX
                                                          : sum_add[msa_pkg::SUM_W-1:0];

    // Divider request: launch from the scan step on a pending channel
    assign div_req.start    = (state_reg == msa_pkg::S_SCAN) && (mask_reg != '0)
                              && mask_reg[idx_reg];
    assign div_req.dividend = sums_reg[idx_reg];
    assign div_req.divisor  = divisor_reg;

    msa_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        mask_next    = mask_reg;
        count_next   = count_reg;
        divisor_next = divisor_reg;
        sum_we       = 1'b0;
        sum_wdata    = sum_sat;
        case (state_reg)
            msa_pkg::S_IDLE:
            begin
                if (in_accept)
                begin
                    mask_next  = s_tdata[CHANNELS-1:0];
                    idx_next   = '0;
                    state_next = msa_pkg::S_ACCUM;
                end
            end
            msa_pkg::S_ACCUM:
            begin
                sum_we    = mask_reg[idx_reg];
                sum_wdata = sum_sat;
                if (idx_last)
                begin
                    state_next = msa_pkg::S_COUNT;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            msa_pkg::S_COUNT:
            begin
                idx_next = '0;
                if (count_inc >= window)
                begin
                    count_next   = '0;
                    divisor_next = count_inc;
                    state_next   = (mask_reg != '0) ? msa_pkg::S_SCAN : msa_pkg::S_IDLE;
                end
                else
                begin
                    count_next = count_inc;
                    state_next = msa_pkg::S_IDLE;
                end
            end
            msa_pkg::S_SCAN:
            begin
                if (mask_reg == '0)
                begin
                    state_next = msa_pkg::S_IDLE;
                end
                else if (mask_reg[idx_reg])
                begin
                    // Hand the sum to the divider and clear it
                    sum_we     = 1'b1;
                    sum_wdata  = '0;
                    state_next = msa_pkg::S_DIV;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            msa_pkg::S_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = msa_pkg::S_EMIT;
                end
            end
            msa_pkg::S_EMIT:
            begin
                if (out_free)
                begin
                    mask_next[idx_reg] = 1'b0;
                    state_next         = msa_pkg::S_SCAN;
                end
            end
            default:
            begin
                state_next = msa_pkg::S_IDLE;
            end
        endcase
    end

    // Output valid: set on load, drop when taken
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (out_load)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= msa_pkg::S_IDLE;
            idx_reg       <= '0;
            mask_reg      <= '0;
            count_reg     <= '0;
            avg_count_reg <= msa_pkg::COUNT_W'(1);
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            mask_reg     <= mask_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en)
            begin
                avg_count_reg <= cfg_wr_data;
            end
        end
    end

    // Channel sums, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                sums_reg[i] <= '0;
            end
        end
        else if (sum_we)
        begin
            sums_reg[idx_reg] <= sum_wdata;
        end
    end

    // Payload registers: samples, divisor and output item
    always_ff @(posedge clk)
    begin
        divisor_reg <= divisor_next;
        if (in_accept)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                samples_reg[i] <= s_tdata[msa_pkg::MASK_W + i * SAMPLE_BITS +: SAMPLE_BITS];
            end
        end
        if (out_load)
        begin
            m_tdata_reg <= msa_pkg::OUT_W'({div_rsp.quotient, msa_pkg::CH_W'(idx_reg)});
            m_tlast_reg <= last_flag;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

`ifndef SYNTHESIS
    // Divider is never running while a request can be taken
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !div_rsp.busy)
    else $error("divider busy while accepting a request");

    // Divider finishes only while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == msa_pkg::S_DIV))
    else $error("divider result outside the divide step");

    // The final result of an event leaves no channel pending
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && last_flag) |=> (mask_reg == '0))
    else $error("channels still pending after the final result");
`endif

endmodule

// ===== rtl/core/msa_div.sv =====
// Serial restoring divider: channel sum over event count, clamped to the
// average range. One quotient bit per cycle. Depends on msa_pkg.
`timescale 1ns / 1ps

module msa_div
(
    input  logic              clk,
    input  logic              rst_n,
    input  msa_pkg::div_req_t req,
    output msa_pkg::div_rsp_t rsp
);

    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [msa_pkg::STEP_W-1:0]        step_reg, step_next;
    logic [msa_pkg::SUM_W-1:0]         rem_reg, rem_next;
    logic [msa_pkg::SUM_W-1:0]         dsh_reg, dsh_next;
    logic [msa_pkg::QUO_STEPS-1:0]     quo_reg, quo_next;
    logic                              fits;

    // Trial subtract against the shifted divisor
    assign fits = (rem_reg >= dsh_reg);

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        quo_next  = quo_reg;
        if (req.start)
        begin
            // Load operands, divisor aligned to the clamp bit
            busy_next = 1'b1;
            step_next = msa_pkg::STEP_W'(msa_pkg::QUO_STEPS - 1);
            rem_next  = req.dividend;
            dsh_next  = msa_pkg::SUM_W'(req.divisor) << msa_pkg::AVG_W;
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            // Advance one quotient bit
            if (fits)
            begin
                rem_next = rem_reg - dsh_reg;
            end
            quo_next = {quo_reg[msa_pkg::QUO_STEPS-2:0], fits};
            dsh_next = dsh_reg >> 1;
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // Datapath holds no reset
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        quo_reg <= quo_next;
    end

    // Clamp when the top quotient bit is set
    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg[msa_pkg::QUO_STEPS-1] ? msa_pkg::AVG_MAX
                                                        : quo_reg[msa_pkg::AVG_W-1:0];

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for multichannel_sample_averager_unit: directed and
// random conversion events, checked against a built-in window-average predictor.
// Depends on msa_pkg and the averager RTL.
`timescale 1ns / 1ps

module testbench;

    localparam int MASK_W    = msa_pkg::MASK_W;
    localparam int CH_W      = msa_pkg::CH_W;
    localparam int AVG_W     = msa_pkg::AVG_W;
    localparam int OUT_W     = msa_pkg::OUT_W;
    localparam int SUM_W     = msa_pkg::SUM_W;
    localparam int COUNT_W   = msa_pkg::COUNT_W;
    localparam logic [SUM_W-1:0]   SUM_MAX   = msa_pkg::SUM_MAX;
    localparam logic [AVG_W-1:0]   AVG_MAX   = msa_pkg::AVG_MAX;
    localparam logic [COUNT_W-1:0] COUNT_MAX = msa_pkg::COUNT_MAX;

    localparam int NCH       = 8;
    localparam int SAMPLE_W  = 10;
    localparam int REQ_W     = ((MASK_W + MASK_W * SAMPLE_W + 7) / 8) * 8;
    localparam int SETTLE    = 24;     // covers the processing of an event that produces no result
    localparam int DRAIN_MAX = 4000;   // cycles to wait for pending averages
    localparam int RAND_PER_PHASE = 65;

    // Request layout: mask in the low byte, then sample_ch0 .. sample_ch7
    typedef struct packed {
        logic [NCH-1:0][SAMPLE_W-1:0] sample;
        logic [MASK_W-1:0]            mask;
    } conv_t;

    typedef struct {
        logic [CH_W-1:0]  channel;
        logic [AVG_W-1:0] average;
        logic             last;
    } avg_result_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [COUNT_W-1:0]     cfg_wr_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [REQ_W-1:0]       s_tdata;    // active_mask, sample_ch0 .. sample_ch7
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_W-1:0]       m_tdata;    // channel, average, zero padding
    logic                   m_tlast;

    // Predictor state
    logic [SUM_W-1:0]       sum_acc [NCH];
    logic [COUNT_W-1:0]     win_count;
    logic [COUNT_W-1:0]     window_len;
    avg_result_t            pending_averages [$];

    bit                     idle_on;
    int                     error_count;
    int                     events_sent;
    int                     averages_seen;

    multichannel_sample_averager_unit #(
        .CHANNELS    (NCH),
        .SAMPLE_BITS (SAMPLE_W)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    // 8 ns clock
    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Hard stop in case the pipeline hangs
    initial
    begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Accumulate one accepted event and queue the averages it closes
    task automatic apply_conversion(input conv_t ev);
        logic [SUM_W:0]     grown;
        logic [SUM_W-1:0]   quo;
        logic [COUNT_W-1:0] span;
        avg_result_t        batch [$];
        avg_result_t        res;
        int                 ch;
        span = (window_len == '0) ? COUNT_W'(1) : window_len;
        for (ch = 0; ch < NCH; ch++)
        begin
            if (ev.mask[ch])
            begin
                grown = {1'b0, sum_acc[ch]} + (SUM_W + 1)'(ev.sample[ch]);
                sum_acc[ch] = (grown > {1'b0, SUM_MAX}) ? SUM_MAX : grown[SUM_W-1:0];
            end
        end
        if (ev.mask != '0 && win_count < COUNT_MAX)
            win_count++;
        if (win_count >= span)
        begin
            for (ch = 0; ch < NCH; ch++)
            begin
                if (ev.mask[ch])
                begin
                    quo = sum_acc[ch] / SUM_W'(win_count);
                    res.channel = CH_W'(ch);
                    res.average = (quo > SUM_W'(AVG_MAX)) ? AVG_MAX : quo[AVG_W-1:0];
                    res.last    = 1'b0;
                    batch.push_back(res);
                    sum_acc[ch] = '0;
                end
            end
            if (batch.size() > 0)
                batch[batch.size() - 1].last = 1'b1;
            foreach (batch[k])
                pending_averages.push_back(batch[k]);
            win_count = '0;
        end
    endtask

    // Build an event; a negative fill gives random samples
    function automatic conv_t make_conv(input logic [MASK_W-1:0] mask, input int fill);
        conv_t ev;
        ev.mask = mask;
        for (int ch = 0; ch < NCH; ch++)
            ev.sample[ch] = (fill < 0) ? SAMPLE_W'($urandom) : SAMPLE_W'(fill);
        return ev;
    endfunction

    // Random event with a bias toward empty, full and one-hot masks and edge samples
    function automatic conv_t random_conv();
        conv_t ev;
        int    pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0:       ev.mask = '0;
            1:       ev.mask = '1;
            2:       ev.mask = MASK_W'(1) << $urandom_range(0, NCH - 1);
            default: ev.mask = MASK_W'($urandom);
        endcase
        for (int ch = 0; ch < NCH; ch++)
        begin
            pick = $urandom_range(0, 7);
            if (pick == 0)
                ev.sample[ch] = '0;
            else if (pick == 1)
                ev.sample[ch] = '1;
            else
                ev.sample[ch] = SAMPLE_W'($urandom);
        end
        return ev;
    endfunction

    // Present one request, hold until accepted, then predict
    task automatic send_conversion(input conv_t ev);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ev;
        do
            @(posedge clk);
        while (!s_tready);
        apply_conversion(ev);
        events_sent++;
    endtask

    // Drop valid, wait for every pending average, then let the block settle
    task automatic wait_quiet();
        int waited;
        waited = 0;
        s_tvalid <= 1'b0;
        while (pending_averages.size() != 0 && waited < DRAIN_MAX)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_averages.size() != 0)
        begin
            $display("%0t: %0d expected averages never arrived", $realtime,
                     pending_averages.size());
            error_count += pending_averages.size();
            pending_averages.delete();
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    // Write average_count; only called while the block is quiet
    task automatic write_window(input logic [COUNT_W-1:0] len);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= len;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        window_len = len;
    endtask

    // Reset value of one: full scale, zero, single channel, empty and mixed masks
    task automatic test_full_window();
        send_conversion(make_conv(8'hFF, 1023));
        send_conversion(make_conv(8'hFF, 0));
        send_conversion(make_conv(8'h80, -1));
        send_conversion(make_conv(8'h00, -1));
        send_conversion(make_conv(8'h55, -1));
        send_conversion(make_conv(8'hAA, 1023));
        wait_quiet();
    endtask

    // A window of zero behaves like one
    task automatic test_zero_window();
        write_window('0);
        send_conversion(make_conv(8'h3C, -1));
        send_conversion(make_conv(8'h01, 1));
        wait_quiet();
    endtask

    // A sum kept across windows pushes the quotient past full scale
    task automatic test_average_clamp();
        write_window(COUNT_W'(2));
        send_conversion(make_conv(8'h02, 1023));
        send_conversion(make_conv(8'h01, 1023));
        send_conversion(make_conv(8'h02, 1023));
        send_conversion(make_conv(8'h03, 1023));
        wait_quiet();
    endtask

    // Window lowered below a running count: empty mask clears, nonzero mask closes
    task automatic test_lowered_window();
        write_window(COUNT_W'(5));
        send_conversion(make_conv(8'h0F, -1));
        send_conversion(make_conv(8'hF0, -1));
        send_conversion(make_conv(8'h3C, -1));
        wait_quiet();
        write_window(COUNT_W'(2));
        send_conversion(make_conv(8'h00, -1));
        send_conversion(make_conv(8'h01, -1));
        send_conversion(make_conv(8'h81, -1));
        wait_quiet();
        write_window(COUNT_W'(6));
        send_conversion(make_conv(8'h11, -1));
        send_conversion(make_conv(8'h22, -1));
        send_conversion(make_conv(8'h44, -1));
        wait_quiet();
        write_window(COUNT_W'(2));
        send_conversion(make_conv(8'h18, -1));
        wait_quiet();
    endtask

    // Widest window holds several events; a lowered window then closes every channel
    task automatic test_wide_window();
        write_window(COUNT_MAX);
        repeat (8) send_conversion(make_conv(8'hFF, -1));
        wait_quiet();
        write_window(COUNT_W'(3));
        send_conversion(make_conv(8'hFF, -1));
        wait_quiet();
    endtask

    // Random events over several windows; the final phase runs without idling
    task automatic test_random_traffic();
        logic [COUNT_W-1:0] windows [6];
        windows = '{COUNT_W'(2), COUNT_W'(1), COUNT_W'(3), COUNT_W'(0),
                    COUNT_W'(4), COUNT_W'(5)};
        windows[4] = COUNT_W'($urandom_range(4, 12));
        for (int phase = 0; phase < 6; phase++)
        begin
            idle_on = (phase != 5);
            write_window(windows[phase]);
            repeat (RAND_PER_PHASE) send_conversion(random_conv());
            wait_quiet();
        end
    endtask

    // Result side: random back-pressure bursts
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (idle_on && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    // Compare each accepted result with the oldest expected average
    always @(posedge clk)
    begin : check_results
        avg_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            averages_seen++;
            if (pending_averages.size() == 0)
            begin
                $display("%0t: unexpected result ch=%0d avg=%0d last=%0b", $realtime,
                         m_tdata[CH_W-1:0], m_tdata[CH_W+AVG_W-1:CH_W], m_tlast);
                error_count++;
            end
            else
            begin
                want = pending_averages.pop_front();
                if (m_tdata[CH_W-1:0] !== want.channel ||
                    m_tdata[CH_W+AVG_W-1:CH_W] !== want.average ||
                    m_tdata[OUT_W-1:CH_W+AVG_W] !== '0 ||
                    m_tlast !== want.last)
                begin
                    $display("%0t: mismatch expected ch=%0d avg=%0d last=%0b pad=0, got ch=%0d avg=%0d last=%0b pad=%0h",
                             $realtime, want.channel, want.average, want.last,
                             m_tdata[CH_W-1:0], m_tdata[CH_W+AVG_W-1:CH_W], m_tlast,
                             m_tdata[OUT_W-1:CH_W+AVG_W]);
                    error_count++;
                end
            end
        end
    end

    // Main sequence
    initial
    begin
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        idle_on       = 1'b1;
        error_count   = 0;
        events_sent   = 0;
        averages_seen = 0;
        foreach (sum_acc[ch])
            sum_acc[ch] = '0;
        win_count  = '0;
        window_len = COUNT_W'(1);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_full_window();
        test_zero_window();
        test_average_clamp();
        test_lowered_window();
        test_wide_window();
        test_random_traffic();
        wait_quiet();

        $display("Sent %0d conversion events, checked %0d channel averages", events_sent,
                 averages_seen);
        $display("Windows 0, 1, 2, 3, 5, 6, 4095 and one random; clamp, empty masks, lowered window");
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
